// File: sv/rational_arithmetic_reduce_macros.svh
// Assertion macros shared by the rational arithmetic reduce RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RATIONAL_ARITHMETIC_REDUCE_MACROS_SVH
`define RATIONAL_ARITHMETIC_REDUCE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: implication");
`define ASSERT_NEVER(label, clk, rst_n, a) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
    else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEVER(label, clk, rst_n, a)
`endif
`endif

// File: sv/rar_pkg.sv
// Shared types and widths for the rational arithmetic reduce block.
// No dependencies; imported by every module of the block.
package rar_pkg;
  localparam int OPW = 16;                  // numerator width
  localparam int DW  = OPW - 1;             // denominator width
  localparam int IW  = 2 * OPW;             // signed cross product width
  localparam int MW  = 2 * OPW - 1;         // magnitude width
  localparam int KW  = $clog2(MW + 1);      // shift and bit counters
  localparam int XW  = (IW > 32) ? IW : 32; // output extension width

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                  kind;
    logic signed [OPW-1:0]  num_a;
    logic        [DW-1:0]   den_a;
    logic signed [OPW-1:0]  num_b;
    logic        [DW-1:0]   den_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic        [30:0] res_den;
    status_t            status;
  } out_word_t;

  // One classified job handed from the front to the back.
  typedef struct packed {
    status_t           status;
    logic              trivial;  // result is 0/1 without reduction
    logic              neg;
    logic [MW-1:0]     mag;
    logic [MW-1:0]     den;
  } job_t;
endpackage

// File: sv/rar_front.sv
// Front end: accepts a word, forms the cross products on one multiplier
// and classifies the job. Depends on rar_pkg.
module rar_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rar_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              q_push,
  output rar_pkg::job_t     q_job
);
  import rar_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;
  in_word_t item_r;
  logic [1:0] mcnt_r, mcnt_nxt;
  logic signed [IW-1:0] p_r [3];
  logic signed [OPW:0] ma, mb;
  logic signed [2*OPW+1:0] prod;
  logic signed [OPW:0] ena, enb, eda, edb;
  logic signed [IW-1:0] nsum;
  logic [IW-1:0] nabs, dabs;

  assign ena = {item_r.num_a[OPW-1], item_r.num_a};
  assign enb = {item_r.num_b[OPW-1], item_r.num_b};
  assign eda = $signed({2'b00, item_r.den_a});
  assign edb = $signed({2'b00, item_r.den_b});

  always_comb begin
    case (mcnt_r)
      2'd0: begin
        ma = ena;
        mb = (item_r.kind == KIND_MUL) ? enb : edb;
      end
      2'd1: begin
        ma = enb;
        mb = eda;
      end
      default: begin
        ma = eda;
        mb = (item_r.kind == KIND_DIV) ? enb : edb;
      end
    endcase
  end
  assign prod = ma * mb;

  always_comb begin
    state_nxt = state_r;
    mcnt_nxt  = mcnt_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          state_nxt = F_MUL;
          mcnt_nxt  = 2'd0;
        end
      end
      F_MUL: begin
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd2) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign in_full = (state_r != F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      mcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      mcnt_r  <= mcnt_nxt;
    end
    if (state_r == F_IDLE && in_push) begin
      item_r <= in_word;
    end
    if (state_r == F_MUL) begin
      p_r[mcnt_r] <= prod[IW-1:0];
    end
  end

  always_comb begin
    case (item_r.kind)
      KIND_ADD: nsum = p_r[0] + p_r[1];
      KIND_SUB: nsum = p_r[0] - p_r[1];
      default:  nsum = p_r[0];
    endcase
    nabs = nsum[IW-1] ? (~nsum + 1'b1) : nsum;
    dabs = p_r[2][IW-1] ? (~p_r[2] + 1'b1) : p_r[2];
    q_job.neg = nsum[IW-1] ^ p_r[2][IW-1];
    q_job.mag = nabs[MW-1:0];
    q_job.den = dabs[MW-1:0];
    if (item_r.den_a == '0 || item_r.den_b == '0) begin
      q_job.status = ST_ZERO_DEN;
    end else if (item_r.kind == KIND_DIV && item_r.num_b == '0) begin
      q_job.status = ST_DIV_ZERO;
    end else begin
      q_job.status = ST_OK;
    end
    q_job.trivial = (q_job.status != ST_OK) || (nsum == '0);
  end
endmodule

// File: sv/rar_queue.sv
// Two-entry job queue between front and back end.
// Depends on rar_pkg.
module rar_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rar_pkg::job_t   wr_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rar_pkg::job_t   rd_job
);
  import rar_pkg::*;

  job_t ent_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign rd_job = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
    if (push && !full) begin
      ent_r[wr_ptr_r] <= wr_job;
    end
  end
endmodule

// File: sv/rar_back.sv
// Back end: binary greatest common divisor, then two restoring
// divisions in parallel, and the result register. Depends on rar_pkg.
module rar_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  rar_pkg::job_t      q_job,
  output logic               out_empty,
  input  logic               out_pop,
  output rar_pkg::out_word_t out_word
);
  import rar_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_GCD  = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t state_r;
  status_t st_r;
  logic neg_r;
  logic [MW-1:0] u_r, v_r, g_r, qn_r, qd_r;
  logic [MW:0] rn_r, rd_r;
  logic [KW-1:0] k_r, cnt_r;
  logic [MW:0] tn, td;
  logic bn, bd;
  logic res_valid_r;
  out_word_t res_r;
  logic [XW-1:0] qe, qs;

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  assign tn = {rn_r[MW-1:0], qn_r[MW-1]};
  assign td = {rd_r[MW-1:0], qd_r[MW-1]};
  assign bn = (tn >= {1'b0, g_r});
  assign bd = (td >= {1'b0, g_r});

  assign qe = XW'(qn_r);
  assign qs = neg_r ? (~qe + 1'b1) : qe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            state_r <= q_job.trivial ? B_OUT : B_GCD;
          end
        end
        B_GCD: begin
          if (u_r == v_r) begin
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          if (cnt_r == '0) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!res_valid_r) begin
            res_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end

    case (state_r)
      B_IDLE: begin
        st_r  <= q_job.status;
        neg_r <= q_job.neg && !q_job.trivial;
        u_r   <= q_job.mag;
        v_r   <= q_job.den;
        qn_r  <= q_job.trivial ? '0 : q_job.mag;
        qd_r  <= q_job.trivial ? MW'(1) : q_job.den;
        k_r   <= '0;
      end
      B_GCD: begin
        if (u_r == v_r) begin
          g_r   <= u_r << k_r;
          rn_r  <= '0;
          rd_r  <= '0;
          cnt_r <= KW'(MW - 1);
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r > v_r) begin
          u_r <= u_r - v_r;
        end else begin
          v_r <= v_r - u_r;
        end
      end
      B_DIV: begin
        rn_r  <= bn ? (tn - {1'b0, g_r}) : tn;
        rd_r  <= bd ? (td - {1'b0, g_r}) : td;
        qn_r  <= {qn_r[MW-2:0], bn};
        qd_r  <= {qd_r[MW-2:0], bd};
        cnt_r <= cnt_r - 1'b1;
      end
      B_OUT: begin
        if (!res_valid_r) begin
          res_r.res_num <= $signed(qs[31:0]);
          res_r.res_den <= 31'(XW'(qd_r));
          res_r.status  <= st_r;
        end
      end
      default: ;
    endcase
  end

  assign out_empty = !res_valid_r;
  assign out_word  = res_r;
endmodule

// File: sv/rational_arithmetic_reduce.sv
// Top level of the rational arithmetic reduce block.
// Depends on rar_pkg, rar_front, rar_queue, rar_back and the macro header.
//
// Usage: write a word (operation and two fractions) with in_push while
// in_full is low. Each word gives exactly one result word, in order, on
// out_word while out_empty is low; take it with out_pop.
// The front end holds one word through capture, three products on a
// single multiplier, then classification into a two-entry queue.
// The back end reduces one job at a time. The binary divisor search takes
// one step per cycle, followed by two parallel restoring divisions and
// the load of the result register. Error cases and zero results skip the
// reduction and go straight to the result register.
// Sustained throughput is set by the back end's search and division loop.
// When the receiver stalls, the result register holds its word, the back
// end waits with the next result, the queue fills, and then in_full rises.
// Reset (synchronous, rst_n low) empties the queue and the result register
// and returns both ends to idle; there is no other state.
`include "rational_arithmetic_reduce_macros.svh"
module rational_arithmetic_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rar_pkg::in_word_t  in_word,
  output logic               out_empty,
  input  logic               out_pop,
  output rar_pkg::out_word_t out_word
);
  import rar_pkg::*;

  logic   q_push, q_pop, q_full, q_empty;
  job_t   wr_job, rd_job;

  // The front end classifies and the queue lets it run ahead of the back.
  rar_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (wr_job)
  );

  rar_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (rd_job)
  );

  rar_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_job     (rd_job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  // A visible result never has a zero denominator.
  `ASSERT_NEVER(a_den_nonzero, clk, rst_n, !out_empty && out_word.res_den == '0)
  // An error status always comes with the result 0/1.
  `ASSERT_IMPLIES(a_err_zero, clk, rst_n, !out_empty && out_word.status != ST_OK, out_word.res_num == '0 && out_word.res_den == 31'd1)
  // The front end only pushes into a queue with room.
  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, q_push, !q_full)
  // The back end only pops a queue that holds a job.
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, q_pop, !q_empty)
endmodule
